// File: hw/rtl/modexp_pkg.sv
// Shared types for the modular exponentiation block.
// No dependencies; imported by modexp_mulmod and modular_exponentiation.
package modexp_pkg;

  // Status returned by the bit-serial modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// File: hw/rtl/modexp_mulmod.sv
// Bit-serial modular multiplier: product = (a * b) mod m, one bit of b per cycle.
// Depends on modexp_pkg (mm_stat_t).
module modexp_mulmod #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] m,
  output modexp_pkg::mm_stat_t     stat,
  output logic [OPERAND_WIDTH-1:0] product
);
  import modexp_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  m_r;
  logic [W-1:0]  r_r;
  logic [W-1:0]  r_nxt;
  logic [W:0]    dbl;
  logic [W:0]    sum;
  logic [W:0]    m_ext;

  // r = 2r mod m, then r = r + a mod m when the current bit of b is set.
  always_comb begin
    m_ext = {1'b0, m_r};
    dbl   = {r_r, 1'b0};
    if (dbl >= m_ext) begin
      dbl = dbl - m_ext;
    end
    sum = dbl + (b_r[W-1] ? {1'b0, a_r} : '0);
    if (sum >= m_ext) begin
      sum = sum - m_ext;
    end
    r_nxt = sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator registers, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      m_r <= m;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= {b_r[W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = r_r;

endmodule

// File: hw/rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block (right-to-left square-and-multiply).
// Depends on modexp_pkg and modexp_mulmod.
//
// Usage:
//   Input channel: drive in_base_value, in_power, in_modulus_value and pulse
//   start; the beat is taken on a rising edge where start is high and busy is
//   low. busy stays high until the result is delivered.
//   Result channel: out_residue is valid for exactly one cycle, flagged by
//   out_valid. There is no back-pressure: the receiver must take the beat.
//
// Timing:
//   A zero exponent (or a zero modulus) gives its result in the cycle after the
//   start beat and busy never rises.
//   Otherwise the base is first reduced modulo the modulus, then each exponent
//   bit below the highest set one costs a square and each set bit a multiply.
//   Every one of these is a pass through the bit-serial multiplier with a
//   launch and a collect step around it, so an item takes (1 + H + P) passes,
//   where H is the index of the highest set exponent bit and P the number of
//   set bits. Worst case for OPERAND_WIDTH = 31: 1 + 30 + 31 = 62 passes.
//   The multiplier is the single shared unit that sets the run time of an item.
//
// Reset: synchronous, active low; returns to idle, drops busy and out_valid.
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPERAND_WIDTH-1:0] in_base_value,
  input  logic [OPERAND_WIDTH-1:0] in_power,
  input  logic [OPERAND_WIDTH-1:0] in_modulus_value,
  output logic                     out_valid,
  output logic [OPERAND_WIDTH-1:0] out_residue
);
  import modexp_pkg::*;

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR
  } state_t;

  state_t       state_r;
  logic [W-1:0] sq_r;        // running square
  logic [W-1:0] acc_r;       // running result
  logic [W-1:0] exp_r;       // exponent bits still to consume, LSB first
  logic [W-1:0] mod_r;
  logic         mm_start_r;
  logic [W-1:0] mm_a_r;
  logic [W-1:0] mm_b_r;
  logic         out_valid_r;
  logic [W-1:0] out_residue_r;

  mm_stat_t     mm_stat;
  logic [W-1:0] mm_product;
  logic [W-1:0] exp_shift;

  modexp_mulmod #(
    .OPERAND_WIDTH(W)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start_r),
    .a       (mm_a_r),
    .b       (mm_b_r),
    .m       (mod_r),
    .stat    (mm_stat),
    .product (mm_product)
  );

  assign exp_shift = {1'b0, exp_r[W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mm_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mm_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            mod_r <= in_modulus_value;
            exp_r <= in_power;
            if (in_power == '0) begin
              // zero exponent: 1 for every modulus, no reduction
              out_valid_r   <= 1'b1;
              out_residue_r <= W'(1);
            end else if (in_modulus_value == '0) begin
              out_valid_r   <= 1'b1;
              out_residue_r <= '0;
            end else begin
              // base mod m computed as (1 * base) mod m
              mm_start_r <= 1'b1;
              mm_a_r     <= W'(1);
              mm_b_r     <= in_base_value;
              state_r    <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mm_stat.done) begin
            sq_r       <= mm_product;
            mm_start_r <= 1'b1;
            if (exp_r[0]) begin
              // acc starts at 1 mod m; first product is just the square
              acc_r   <= (mod_r == W'(1)) ? '0 : W'(1);
              mm_a_r  <= (mod_r == W'(1)) ? '0 : W'(1);
              mm_b_r  <= mm_product;
              state_r <= ST_MUL;
            end else begin
              acc_r   <= (mod_r == W'(1)) ? '0 : W'(1);
              mm_a_r  <= mm_product;
              mm_b_r  <= mm_product;
              state_r <= ST_SQR;
            end
          end
        end
        ST_MUL: begin
          if (mm_stat.done) begin
            acc_r <= mm_product;
            if (exp_shift == '0) begin
              // no set bits left: further squares are dead work
              out_valid_r   <= 1'b1;
              out_residue_r <= mm_product;
              state_r       <= ST_IDLE;
            end else begin
              mm_start_r <= 1'b1;
              mm_a_r     <= sq_r;
              mm_b_r     <= sq_r;
              state_r    <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          if (mm_stat.done) begin
            sq_r       <= mm_product;
            exp_r      <= exp_shift;
            mm_start_r <= 1'b1;
            if (exp_shift[0]) begin
              mm_a_r  <= acc_r;
              mm_b_r  <= mm_product;
              state_r <= ST_MUL;
            end else begin
              mm_a_r  <= mm_product;
              mm_b_r  <= mm_product;
              state_r <= ST_SQR;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;

  // An accepted beat either starts work or produces its result next cycle.
  a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted beat neither started work nor produced a result");

  // A result always closes the item: busy is low when it is shown.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  // The multiplier only finishes while the sequencer waits for it.
  a_mm_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_stat.done |-> busy && !mm_stat.busy)
    else $error("multiplier done outside an active item");

  // Only one multiplier pass in flight at a time.
  a_mm_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start_r |-> !mm_stat.busy)
    else $error("multiplier launched while busy");

endmodule
